[rtl/ppu_update_stream_decoder_assert.svh]
// Assertion macros shared by the decoder RTL.
`ifndef PPU_UPDATE_STREAM_DECODER_ASSERT_SVH
`define PPU_UPDATE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication.
`define PUSD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PUSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pusd_pkg.sv]
package pusd_pkg;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int COL_W   = 6;
   localparam int ROW_W   = 5;
   localparam int COUNT_W = 6;
   localparam int BUF_DEPTH = 63;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);

   localparam logic [KIND_W-1:0] KIND_TILE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ATTR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

   localparam logic [7:0] HIGH_MIN = 8'h20;
   localparam logic [7:0] HIGH_END = 8'hFF;
   localparam logic [3:0] TILE_NIB = 4'h2;
   localparam logic [10:0] PAL_LINE = 11'h1F8;
   localparam logic [3:0] ATTR_ROWS = 4'hF;

endpackage

[rtl/pusd_ifs.sv]
interface pusd_req_if;
   logic                          valid;
   logic                          ready;
   logic [pusd_pkg::BYTE_W-1:0]   byte_in;
   logic                          restart;

   modport source (output valid, output byte_in, output restart, input ready);
   modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

interface pusd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pusd_pkg::KIND_W-1:0]   kind;
   logic [pusd_pkg::COL_W-1:0]    col;
   logic [pusd_pkg::ROW_W-1:0]    row;
   logic [pusd_pkg::BYTE_W-1:0]   value;
   logic                          last;

   modport source (output valid, output kind, output col, output row, output value,
                   output last, input ready);
   modport sink   (input valid, input kind, input col, input row, input value,
                   input last, output ready);
endinterface

[rtl/ppu_update_stream_decoder.sv]
// Video update stream decoder.
// req_ch carries one command stream byte per request (byte_in, restart).
// rsp_ch carries screen cells: kind, col, row, value, and last on the final
// cell caused by a request.  Both channels use valid/ready.
// Address, control and non-final data bytes are taken one per cycle.
// The final data byte of a command starts an expansion: each cell is read
// from the run buffer in S_READ and offered in S_SEND, so a new cell is not
// read until the previous one is taken.  req_ready stays low until the last
// cell (or the single error result) is taken.  Palette lines and zero counts
// give no cells and return the parser to expect a high address byte.
// A stalled receiver holds the current cell and freezes the expansion.
// Synchronous reset returns the parser to expect a high address byte; the
// run buffer is not cleared and needs no clearing pass.
// An end mark or bad address stops parsing until a request with restart.
module ppu_update_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   pusd_req_if.sink   req_ch,
   pusd_rsp_if.source rsp_ch
);
   import pusd_pkg::*;

`include "ppu_update_stream_decoder_assert.svh"

   typedef enum logic [2:0] {
      S_HIGH, S_LOW, S_CTRL, S_DATA, S_STOP, S_READ, S_SEND
   } state_type;

   state_type            state_ff;
   logic [15:0]          addr_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   left_ff;
   logic                 vert_ff;
   logic                 rep_ff;
   logic [COUNT_W-1:0]   k_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [COL_W-1:0]     col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [BYTE_W-1:0]    rd_data_ff;

   logic [BYTE_W-1:0]    buf_mem [0:BUF_DEPTH-1];

   logic                 req_fire;
   logic                 is_err;
   logic                 is_attr;
   logic                 is_pal;
   logic                 done_k;
   logic                 wr_en;
   logic [BUF_AW-1:0]    wr_idx;
   logic [BUF_AW-1:0]    rd_idx;
   logic [COUNT_W-1:0]   idx_in;
   logic [COL_W-1:0]     col_in;
   logic [ROW_W-1:0]     row_in;

   assign req_ch.ready = (state_ff != S_READ) && (state_ff != S_SEND);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = (state_ff == S_SEND);
   assign rsp_ch.kind  = kind_ff;
   assign rsp_ch.col   = col_ff;
   assign rsp_ch.row   = row_ff;
   assign rsp_ch.value = (kind_ff == KIND_ERR) ? '0 : rd_data_ff;
   assign done_k       = (k_ff == (count_ff - COUNT_W'(1)));
   assign rsp_ch.last  = (kind_ff == KIND_ERR) || done_k;

   assign is_pal  = (addr_ff[15:5] == PAL_LINE);
   assign is_err  = (addr_ff[15:12] != TILE_NIB) && !is_pal;
   assign is_attr = (addr_ff[9:6] == ATTR_ROWS);

   assign idx_in = count_ff - left_ff;
   assign wr_en  = req_fire && !req_ch.restart && (state_ff == S_DATA);
   assign wr_idx = rep_ff ? '0 : idx_in[BUF_AW-1:0];
   assign rd_idx = rep_ff ? '0 : k_ff[BUF_AW-1:0];

   // Cell position stepping unit.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (kind_ff == KIND_ATTR) begin
         if (col_ff[2:0] == 3'd7) begin
            col_in[2:0] = 3'd0;
            row_in[2:0] = row_ff[2:0] + 3'd1;
         end else begin
            col_in[2:0] = col_ff[2:0] + 3'd1;
         end
      end else if (vert_ff) begin
         row_in = row_ff + 5'd1;
      end else if (col_ff[4:0] == 5'd31) begin
         col_in[4:0] = 5'd0;
         row_in      = row_ff + 5'd1;
      end else begin
         col_in[4:0] = col_ff[4:0] + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_idx] <= req_ch.byte_in;
      end
      rd_data_ff <= buf_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HIGH;
         addr_ff  <= '0;
         count_ff <= '0;
         left_ff  <= '0;
         vert_ff  <= 1'b0;
         rep_ff   <= 1'b0;
         k_ff     <= '0;
         kind_ff  <= KIND_TILE;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (req_fire && req_ch.restart) begin
         state_ff <= S_HIGH;
      end else begin
         case (state_ff)
            S_HIGH: begin
               if (req_fire) begin
                  addr_ff  <= {req_ch.byte_in, 8'h00};
                  count_ff <= '0;
                  left_ff  <= '0;
                  vert_ff  <= 1'b0;
                  rep_ff   <= 1'b0;
                  if (req_ch.byte_in < HIGH_MIN || req_ch.byte_in == HIGH_END) begin
                     state_ff <= S_STOP;
                  end else begin
                     state_ff <= S_LOW;
                  end
               end
            end
            S_LOW: begin
               if (req_fire) begin
                  addr_ff[7:0] <= req_ch.byte_in;
                  state_ff     <= S_CTRL;
               end
            end
            S_CTRL: begin
               if (req_fire) begin
                  count_ff <= req_ch.byte_in[COUNT_W-1:0];
                  left_ff  <= req_ch.byte_in[COUNT_W-1:0];
                  vert_ff  <= req_ch.byte_in[7];
                  rep_ff   <= req_ch.byte_in[6];
                  state_ff <= S_DATA;
               end
            end
            S_DATA: begin
               if (req_fire) begin
                  if (!rep_ff && left_ff > COUNT_W'(1)) begin
                     left_ff <= left_ff - COUNT_W'(1);
                  end else if (is_err) begin
                     kind_ff  <= KIND_ERR;
                     col_ff   <= '0;
                     row_ff   <= '0;
                     state_ff <= S_SEND;
                  end else if (is_pal || count_ff == '0) begin
                     state_ff <= S_HIGH;
                  end else begin
                     k_ff <= '0;
                     if (is_attr) begin
                        kind_ff <= KIND_ATTR;
                        col_ff  <= {2'b00, addr_ff[10], addr_ff[2:0]};
                        row_ff  <= {2'b00, addr_ff[5:3]};
                     end else begin
                        kind_ff <= KIND_TILE;
                        col_ff  <= {addr_ff[10], addr_ff[4:0]};
                        row_ff  <= addr_ff[9:5];
                     end
                     state_ff <= S_READ;
                  end
               end
            end
            S_STOP: begin
               state_ff <= S_STOP;
            end
            S_READ: begin
               state_ff <= S_SEND;
            end
            S_SEND: begin
               if (rsp_ch.ready) begin
                  if (kind_ff == KIND_ERR) begin
                     state_ff <= S_STOP;
                  end else if (done_k) begin
                     state_ff <= S_HIGH;
                  end else begin
                     k_ff     <= k_ff + COUNT_W'(1);
                     col_ff   <= col_in;
                     row_ff   <= row_in;
                     state_ff <= S_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_STOP;
            end
         endcase
      end
   end

   `PUSD_ASSERT_NOW(a_no_overlap, clock, reset, rsp_ch.valid, !req_ch.ready, "request taken during expansion")
   `PUSD_ASSERT_NOW(a_err_last, clock, reset, rsp_ch.valid && rsp_ch.kind == KIND_ERR, rsp_ch.last && rsp_ch.col == '0 && rsp_ch.row == '0, "error result malformed")
   `PUSD_ASSERT_NEXT(a_err_stop, clock, reset, rsp_ch.valid && rsp_ch.ready && rsp_ch.kind == KIND_ERR, state_ff == S_STOP, "parser not stopped after error")

endmodule

[dv/tb_ppu_update_stream_decoder.sv]
`timescale 1ns / 100ps

module tb_ppu_update_stream_decoder;
   import pusd_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int STREAM_BYTES  = 330;
   localparam int HOLD_AFTER    = 60;
   localparam int HOLD_CYCLES   = 200;
   localparam int OPENING_LEN   = 29;

   // {restart, byte}
   localparam logic [8:0] OPENING [OPENING_LEN] = '{
      9'h020, 9'h000, 9'h002, 9'h011, 9'h022,   // tile line, horizontal
      9'h02F, 9'h0BF, 9'h0C4, 9'h07E,           // tile line, vertical repeat, row wrap
      9'h027, 9'h0FE, 9'h043, 9'h0A5,           // attribute line, repeat, block wrap
      9'h03F, 9'h01F, 9'h001, 9'h0FF,           // palette line
      9'h024, 9'h040, 9'h080, 9'h05A,           // zero count
      9'h030, 9'h000, 9'h041, 9'h099,           // bad address
      9'h1FF,                                   // restart
      9'h0FF, 9'h020,                           // end mark, ignored byte
      9'h100                                    // restart
   };

   class cell_scoreboard;
      typedef enum logic [2:0] {
         EXPECT_HIGH, EXPECT_LOW, EXPECT_CTRL, TAKE_DATA, STOPPED
      } parse_phase_type;

      typedef struct packed {
         logic [KIND_W-1:0] kind;
         logic [COL_W-1:0]  col;
         logic [ROW_W-1:0]  row;
         logic [BYTE_W-1:0] value;
         logic              last;
      } cell_type;

      parse_phase_type   phase;
      logic [15:0]       target_address;
      logic [5:0]        run_count;
      logic [5:0]        bytes_left;
      logic              vertical_run;
      logic              repeat_run;
      logic [7:0]        run_buffer [BUF_DEPTH];
      cell_type          expected_cells [$];

      int mismatches;
      int requests_noted;
      int restarts_noted;
      int commands_done;
      int tile_cells;
      int attr_cells;
      int error_results;

      function new();
         phase = EXPECT_HIGH;
         target_address = '0;
         run_count = '0;
         bytes_left = '0;
         vertical_run = 1'b0;
         repeat_run = 1'b0;
      endfunction

      task report(string msg);
         if (mismatches < 50) $display("MISMATCH @%0t: %s", $time, msg);
         mismatches++;
      endtask

      function void push_cell(logic [KIND_W-1:0] kind, int col, int row, logic [7:0] value);
         cell_type c;
         c.kind  = kind;
         c.col   = COL_W'(col);
         c.row   = ROW_W'(row);
         c.value = value;
         c.last  = 1'b0;
         expected_cells.insert(expected_cells.size(), c);
      endfunction

      function void expand_command();
         int x, y, x0, y0, page, off, first;
         logic [15:0] a;
         a = target_address;
         first = expected_cells.size();
         commands_done++;
         if (!((a >= 16'h2000 && a < 16'h3000) || (a >= 16'h3F00 && a < 16'h3F20))) begin
            push_cell(KIND_ERR, 0, 0, 8'h00);
            phase = STOPPED;
         end else begin
            phase = EXPECT_HIGH;
            if (a < 16'h3F00) begin
               page = int'(a[11:10]);
               off  = int'(a[9:0]);
               if (a[9:6] == 4'hF) begin
                  off = off - 'h3C0;
                  x = off % 8 + 8 * (page % 2);
                  y = off / 8 + 8 * (page / 2);
                  x0 = x - x % 8;
                  for (int k = 0; k < int'(run_count); k++) begin
                     push_cell(KIND_ATTR, x % 16, y % 8,
                               repeat_run ? run_buffer[0] : run_buffer[k]);
                     x++;
                     if (x >= x0 + 8) begin
                        x = x0;
                        y = (y + 1) % 256;
                     end
                  end
               end else begin
                  x = off % 32 + 32 * (page % 2);
                  y = off / 32 + 32 * (page / 2);
                  x0 = x - x % 32;
                  y0 = y - y % 32;
                  for (int k = 0; k < int'(run_count); k++) begin
                     push_cell(KIND_TILE, x % 64, y % 32,
                               repeat_run ? run_buffer[0] : run_buffer[k]);
                     if (vertical_run) y++;
                     else x++;
                     if (x >= x0 + 32) begin
                        x = x0;
                        y++;
                     end
                     if (y >= y0 + 32) y = y0;
                  end
               end
            end
         end
         if (expected_cells.size() > first)
            expected_cells[expected_cells.size() - 1].last = 1'b1;
      endfunction

      function void note_request(logic [7:0] data_byte, logic restart_bit);
         logic [5:0] slot;
         requests_noted++;
         if (restart_bit) begin
            phase = EXPECT_HIGH;
            restarts_noted++;
            return;
         end
         case (phase)
            EXPECT_HIGH: begin
               target_address = {data_byte, 8'h00};
               run_count = '0;
               bytes_left = '0;
               vertical_run = 1'b0;
               repeat_run = 1'b0;
               phase = (data_byte < HIGH_MIN || data_byte == HIGH_END) ? STOPPED : EXPECT_LOW;
            end
            EXPECT_LOW: begin
               target_address[7:0] = data_byte;
               phase = EXPECT_CTRL;
            end
            EXPECT_CTRL: begin
               run_count = data_byte[5:0];
               vertical_run = data_byte[7];
               repeat_run = data_byte[6];
               bytes_left = data_byte[5:0];
               phase = TAKE_DATA;
            end
            TAKE_DATA: begin
               slot = run_count - bytes_left;
               if (repeat_run) begin
                  run_buffer[0] = data_byte;
                  expand_command();
               end else begin
                  if (slot < BUF_DEPTH) run_buffer[slot] = data_byte;
                  if (bytes_left > 6'd1) bytes_left--;
                  else expand_command();
               end
            end
            default: phase = STOPPED;
         endcase
      endfunction

      task check_cell(logic [KIND_W-1:0] kind, logic [COL_W-1:0] col,
                      logic [ROW_W-1:0] row, logic [BYTE_W-1:0] value,
                      logic last);
         cell_type want;
         if (expected_cells.size() == 0) begin
            report($sformatf("unexpected cell kind %0d col %0d row %0d value %02h last %0b",
                             kind, col, row, value, last));
            return;
         end
         want = expected_cells.pop_front();
         if (want.kind == KIND_TILE) tile_cells++;
         else if (want.kind == KIND_ATTR) attr_cells++;
         else error_results++;
         if (kind !== want.kind || col !== want.col || row !== want.row ||
             value !== want.value || last !== want.last)
            report($sformatf("cell kind/col/row/value/last got %0d/%0d/%0d/%02h/%0b exp %0d/%0d/%0d/%02h/%0b",
                             kind, col, row, value, last,
                             want.kind, want.col, want.row, want.value, want.last));
      endtask

      task check_leftover();
         if (expected_cells.size() != 0)
            report($sformatf("%0d expected cells never arrived", expected_cells.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   pusd_req_if req_ch ();
   pusd_rsp_if rsp_ch ();

   ppu_update_stream_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cell_scoreboard sb;
   int accepted_requests = 0;
   int stream_bytes = 0;
   int burst_left = 0;
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request(req_ch.byte_in, req_ch.restart);
            accepted_requests++;
         end
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_cell(rsp_ch.kind, rsp_ch.col, rsp_ch.row, rsp_ch.value, rsp_ch.last);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("ppu_update_stream_decoder verification failed");
            $finish;
         end
      end
   end

   // receiver: segments of random ready density, one long hold-off
   initial begin
      int seg_left;
      int ready_pct;
      int hold_left;
      bit held;
      seg_left = 0;
      ready_pct = 100;
      hold_left = 0;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && accepted_requests >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(10, 60);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 75;
                  2: ready_pct = 50;
                  default: ready_pct = 25;
               endcase
            end
            seg_left--;
            rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   task automatic send_request(input logic [7:0] data_byte, input logic restart_bit);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.byte_in <= data_byte;
      req_ch.restart <= restart_bit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (!restart_bit) stream_bytes++;
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_cells.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // one command, mostly well formed; end marks, bad addresses and cut-off
   // commands are followed by a restart
   task automatic send_command();
      logic [7:0] hi, lo, ctrl;
      int pick, count, n;
      logic bad;
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
         hi = ($urandom_range(0, 3) == 0) ? HIGH_END : 8'($urandom_range(0, 31));
         send_request(hi, 1'b0);
         repeat ($urandom_range(0, 3)) send_request(8'($urandom), 1'b0);
         send_request(8'($urandom), 1'b1);
         return;
      end
      if (pick < 70) begin
         hi = 8'($urandom_range(8'h20, 8'h2F));
         lo = 8'($urandom);
         if ($urandom_range(0, 2) == 0) begin
            hi[1:0] = 2'b11;
            lo[7:6] = 2'b11;
         end
      end else if (pick < 78) begin
         hi = 8'h3F;
         lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
      end else begin
         hi = 8'($urandom_range(8'h30, 8'hFE));
         lo = 8'($urandom);
      end
      bad = !((hi >= 8'h20 && hi <= 8'h2F) || (hi == 8'h3F && lo < 8'h20));
      send_request(hi, 1'b0);
      send_request(lo, 1'b0);
      if ($urandom_range(0, 24) == 0) begin
         send_request(8'($urandom), 1'b1);
         return;
      end
      pick = $urandom_range(0, 99);
      count = (pick < 85) ? $urandom_range(0, 8) :
              (pick < 95) ? $urandom_range(9, 32) : $urandom_range(33, 63);
      ctrl = {1'($urandom), 1'($urandom), 6'(count)};
      send_request(ctrl, 1'b0);
      n = (ctrl[6] || count == 0) ? 1 : count;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 199) == 0) begin
            send_request(8'($urandom), 1'b1);
            return;
         end
         send_request(8'($urandom), 1'b0);
      end
      if (bad) begin
         repeat ($urandom_range(0, 2)) send_request(8'($urandom), 1'b0);
         send_request(8'($urandom), 1'b1);
      end
   endtask

   initial begin
      sb = new();
      req_ch.valid   <= 1'b0;
      req_ch.byte_in <= '0;
      req_ch.restart <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < OPENING_LEN; i++)
         send_request(OPENING[i][7:0], OPENING[i][8]);
      wait_for_drain();

      while (stream_bytes < STREAM_BYTES) send_command();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.check_leftover();

      $display("Stream of %0d requests (%0d restarts) drove %0d completed commands.",
               sb.requests_noted, sb.restarts_noted, sb.commands_done);
      $display("Checked %0d tile cells, %0d attribute cells and %0d bad address results.",
               sb.tile_cells, sb.attr_cells, sb.error_results);
      if (sb.mismatches == 0) begin
         $display("ppu_update_stream_decoder verification clean");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("ppu_update_stream_decoder verification failed");
      end
      $finish;
   end

endmodule
